// ----- rtl/core/drp_pkg.sv -----
// drp_pkg: shared result types, field kind codes and helper for the dns response parser
package drp_pkg;

  localparam logic [4:0] K_ID        = 5'd0;
  localparam logic [4:0] K_NAME_CHAR = 5'd6;
  localparam logic [4:0] K_NAME_END  = 5'd7;
  localparam logic [4:0] K_QTYPE     = 5'd8;
  localparam logic [4:0] K_QCLASS    = 5'd9;
  localparam logic [4:0] K_RTYPE     = 5'd10;
  localparam logic [4:0] K_RCLASS    = 5'd11;
  localparam logic [4:0] K_TTL       = 5'd12;
  localparam logic [4:0] K_RDLEN     = 5'd13;
  localparam logic [4:0] K_IPV4      = 5'd14;
  localparam logic [4:0] K_DONE      = 5'd15;
  localparam logic [4:0] K_ERROR     = 5'd16;

  localparam logic [31:0] ERR_TRUNCATED = 32'd0;
  localparam logic [31:0] ERR_BAD_LABEL = 32'd1;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_MX    = 16'd15;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] LABEL_MAX = 8'd63;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  section;
    logic [31:0] value;
  } res_t;

  // results made by one byte, at most two
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } emit_t;

  function automatic emit_t emit(emit_t e, logic [4:0] k, logic [1:0] sec, logic [31:0] v);
    res_t r;
    r = '{kind: k, section: sec, value: v};
    if (e.n == 2'd0) begin
      e.r0 = r;
      e.n  = 2'd1;
    end else if (e.n == 2'd1) begin
      e.r1 = r;
      e.n  = 2'd2;
    end
    return e;
  endfunction

endpackage

// ----- rtl/core/drp_if.sv -----
// drp_if: valid/ready channel interfaces for message bytes and parse results
interface drp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface drp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_kind;
  logic [1:0]  section;
  logic [31:0] field_value;
  modport source (output valid, output field_kind, output section, output field_value,
                  input ready);
  modport sink (input valid, input field_kind, input section, input field_value,
                output ready);
endinterface

// ----- rtl/core/dns_response_parser.sv -----
// dns_response_parser: top level, input byte register, parser and result queue
// a byte is registered on input; its results are written to the queue and offered
// throughput: one byte per cycle while bytes give at most one result each and the
// queue has room; a byte giving two results holds the single result port for both
// reset: synchronous active-low rst_n returns the parse state to the header id
// phase and empties the input register and the result queue
module dns_response_parser (
  input  logic      clk,
  input  logic      rst_n,
  drp_in_if.sink    in_chan,
  drp_out_if.source out_chan
);
  import drp_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       adv;
  logic       q_full;
  logic       push;
  emit_t      es;

  assign adv           = in_vld_r && !q_full;
  assign in_chan.ready = !in_vld_r || adv;
  assign push          = adv && (es.n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_last_r <= in_chan.frame_end;
    end
  end

  drp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .data_byte (in_byte_r),
    .frame_end (in_last_r),
    .res       (es)
  );

  drp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (es),
    .full      (q_full),
    .out_ch    (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("result queue written while full");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("stalled input byte lost");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.field_kind == K_ERROR) |->
      (out_chan.field_value == ERR_TRUNCATED || out_chan.field_value == ERR_BAD_LABEL))
    else $error("unknown error code");
`endif

endmodule

// ----- rtl/core/drp_parser.sv -----
// drp_parser: per-byte parse state and next-state logic producing up to two results
module drp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    data_byte,
  input  logic          frame_end,
  output drp_pkg::emit_t res
);
  import drp_pkg::*;

  typedef enum logic [4:0] {
    PH_ID        = 5'd0,
    PH_FLAGS     = 5'd1,
    PH_QDCNT     = 5'd2,
    PH_ANCNT     = 5'd3,
    PH_NSCNT     = 5'd4,
    PH_ARCNT     = 5'd5,
    PH_QNAME_LEN = 5'd6,
    PH_QNAME_CHR = 5'd7,
    PH_QTYPE     = 5'd8,
    PH_QCLASS    = 5'd9,
    PH_RNAME_LEN = 5'd10,
    PH_RNAME_CHR = 5'd11,
    PH_RTYPE     = 5'd12,
    PH_RCLASS    = 5'd13,
    PH_TTL       = 5'd14,
    PH_RDLEN     = 5'd15,
    PH_IPV4      = 5'd16,
    PH_PREF      = 5'd17,
    PH_DNAME_LEN = 5'd18,
    PH_DNAME_CHR = 5'd19,
    PH_FINISHED  = 5'd20
  } phase_t;

  typedef enum logic [1:0] {
    FMT_IPV4 = 2'd0,
    FMT_NAME = 2'd1,
    FMT_MX   = 2'd2
  } fmt_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  bif;
    logic [31:0] acc;
    logic [5:0]  lab;
    logic        started;
    logic [15:0] qtype;
    logic [15:0] an;
    logic [15:0] ns;
    logic [15:0] ar;
    logic [1:0]  sec;
    fmt_t        fmt;
    logic        failed;
  } st_t;

  function automatic st_t st_reset();
    st_t s;
    s = '0;
    s.phase = PH_ID;
    s.fmt   = FMT_IPV4;
    return s;
  endfunction

  function automatic st_t next_rec(st_t s);
    priority if (s.an != 16'd0) begin
      s.an  = s.an - 16'd1;
      s.sec = 2'd1;
    end else if (s.ns != 16'd0) begin
      s.ns  = s.ns - 16'd1;
      s.sec = 2'd2;
    end else if (s.ar != 16'd0) begin
      s.ar  = s.ar - 16'd1;
      s.sec = 2'd3;
    end else begin
      s.phase = PH_FINISHED;
      return s;
    end
    priority if (s.qtype == TYPE_A) begin
      s.fmt = FMT_IPV4;
    end else if (s.qtype == TYPE_CNAME) begin
      s.fmt = FMT_NAME;
    end else if (s.sec == 2'd1) begin
      s.fmt = (s.qtype == TYPE_MX) ? FMT_MX : FMT_NAME;
    end else if (s.sec == 2'd2) begin
      s.fmt = FMT_NAME;
    end else begin
      s.fmt = FMT_IPV4;
    end
    s.phase   = PH_RNAME_LEN;
    s.started = 1'b0;
    return s;
  endfunction

  st_t         st_r;
  st_t         st_nxt;
  emit_t       es;
  logic [31:0] acc_sh;
  logic [1:0]  bif_inc;
  logic [15:0] w16;

  always_comb begin
    st_nxt  = st_r;
    es      = '0;
    acc_sh  = {st_r.acc[23:0], data_byte};
    bif_inc = st_r.bif + 2'd1;
    w16     = acc_sh[15:0];
    if (st_r.failed || st_r.phase == PH_FINISHED) begin
      if (frame_end) begin
        st_nxt = st_reset();
      end
    end else begin
      unique case (st_r.phase)
        PH_ID, PH_FLAGS, PH_QDCNT, PH_ANCNT, PH_NSCNT, PH_ARCNT: begin
          st_nxt.acc = acc_sh;
          st_nxt.bif = bif_inc;
          if (bif_inc == 2'd2) begin
            st_nxt.bif = 2'd0;
            st_nxt.acc = '0;
            // header kinds follow the header phase order
            es = emit(es, K_ID + 5'(st_r.phase), st_r.sec, {16'd0, w16});
            if (st_r.phase == PH_ANCNT) st_nxt.an = w16;
            if (st_r.phase == PH_NSCNT) st_nxt.ns = w16;
            if (st_r.phase == PH_ARCNT) st_nxt.ar = w16;
            st_nxt.phase = phase_t'(st_r.phase + 5'd1);
          end
        end
        PH_QNAME_LEN, PH_RNAME_LEN, PH_DNAME_LEN: begin
          if (data_byte == 8'd0) begin
            es = emit(es, K_NAME_END, st_r.sec, 32'd0);
            if (st_r.phase == PH_QNAME_LEN) begin
              st_nxt.phase = PH_QTYPE;
            end else if (st_r.phase == PH_RNAME_LEN) begin
              st_nxt.phase = PH_RTYPE;
            end else begin
              st_nxt = next_rec(st_nxt);
              if (st_nxt.phase == PH_FINISHED) es = emit(es, K_DONE, st_nxt.sec, 32'd0);
            end
          end else if (data_byte > LABEL_MAX) begin
            st_nxt.failed = 1'b1;
            es = emit(es, K_ERROR, st_r.sec, ERR_BAD_LABEL);
          end else begin
            if (st_r.started) es = emit(es, K_NAME_CHAR, st_r.sec, {24'd0, CHAR_DOT});
            st_nxt.started = 1'b1;
            st_nxt.lab     = data_byte[5:0];
            st_nxt.phase   = phase_t'(st_r.phase + 5'd1);
          end
        end
        PH_QNAME_CHR, PH_RNAME_CHR, PH_DNAME_CHR: begin
          es = emit(es, K_NAME_CHAR, st_r.sec, {24'd0, data_byte});
          st_nxt.lab = st_r.lab - 6'd1;
          if (st_nxt.lab == 6'd0) st_nxt.phase = phase_t'(st_r.phase - 5'd1);
        end
        PH_QTYPE, PH_QCLASS, PH_RTYPE, PH_RCLASS, PH_RDLEN: begin
          st_nxt.acc = acc_sh;
          st_nxt.bif = bif_inc;
          if (bif_inc == 2'd2) begin
            st_nxt.bif = 2'd0;
            st_nxt.acc = '0;
            unique case (st_r.phase)
              PH_QTYPE: begin
                st_nxt.qtype = w16;
                es = emit(es, K_QTYPE, st_r.sec, {16'd0, w16});
                st_nxt.phase = PH_QCLASS;
              end
              PH_QCLASS: begin
                es = emit(es, K_QCLASS, st_r.sec, {16'd0, w16});
                st_nxt = next_rec(st_nxt);
                if (st_nxt.phase == PH_FINISHED) es = emit(es, K_DONE, st_nxt.sec, 32'd0);
              end
              PH_RTYPE: begin
                es = emit(es, K_RTYPE, st_r.sec, {16'd0, w16});
                st_nxt.phase = PH_RCLASS;
              end
              PH_RCLASS: begin
                es = emit(es, K_RCLASS, st_r.sec, {16'd0, w16});
                st_nxt.phase = PH_TTL;
              end
              default: begin
                es = emit(es, K_RDLEN, st_r.sec, {16'd0, w16});
                st_nxt.started = 1'b0;
                unique case (st_r.fmt)
                  FMT_IPV4: st_nxt.phase = PH_IPV4;
                  FMT_MX:   st_nxt.phase = PH_PREF;
                  default:  st_nxt.phase = PH_DNAME_LEN;
                endcase
              end
            endcase
          end
        end
        PH_TTL, PH_IPV4: begin
          st_nxt.acc = acc_sh;
          st_nxt.bif = bif_inc;
          if (bif_inc == 2'd0) begin
            st_nxt.acc = '0;
            if (st_r.phase == PH_TTL) begin
              es = emit(es, K_TTL, st_r.sec, acc_sh);
              st_nxt.phase = PH_RDLEN;
            end else begin
              es = emit(es, K_IPV4, st_r.sec, acc_sh);
              st_nxt = next_rec(st_nxt);
              if (st_nxt.phase == PH_FINISHED) es = emit(es, K_DONE, st_nxt.sec, 32'd0);
            end
          end
        end
        PH_PREF: begin
          st_nxt.acc = acc_sh;
          st_nxt.bif = bif_inc;
          if (bif_inc == 2'd2) begin
            st_nxt.bif   = 2'd0;
            st_nxt.acc   = '0;
            st_nxt.phase = PH_DNAME_LEN;
          end
        end
        default: begin
          st_nxt.failed = 1'b1;
          es = emit(es, K_ERROR, st_r.sec, ERR_BAD_LABEL);
        end
      endcase
      if (frame_end) begin
        if (!st_nxt.failed && st_nxt.phase != PH_FINISHED) begin
          es = emit(es, K_ERROR, st_nxt.sec, ERR_TRUNCATED);
        end
        st_nxt = st_reset();
      end
    end
  end

  assign res = es;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset();
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ----- rtl/core/drp_result_queue.sv -----
// drp_result_queue: two-entry queue of per-byte result groups, one item per ready cycle
module drp_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  drp_pkg::emit_t   push_data,
  output logic             full,
  drp_out_if.source        out_ch
);
  import drp_pkg::*;

  emit_t      ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       sub_r;
  emit_t      head;
  res_t       cur;
  logic       pop;
  logic       last_slot;
  logic       pop_ent;

  assign head      = ent_r[rd_r];
  assign cur       = sub_r ? head.r1 : head.r0;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_ch.valid && out_ch.ready;
  assign last_slot = sub_r || (head.n != 2'd2);
  assign pop_ent   = pop && last_slot;

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.field_kind  = cur.kind;
  assign out_ch.section     = cur.section;
  assign out_ch.field_value = cur.value;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
      sub_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) begin
        if (last_slot) begin
          sub_r <= 1'b0;
          rd_r  <= ~rd_r;
        end else begin
          sub_r <= 1'b1;
        end
      end
      unique case ({push, pop_ent})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- bench/dns_response_parser_tb.sv -----
// dns_response_parser_tb: byte-stream stimulus, field-by-field prediction and result checks
module dns_response_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  typedef enum logic [4:0] {
    P_ID, P_FLAGS, P_QDCOUNT, P_ANCOUNT, P_NSCOUNT, P_ARCOUNT,
    P_QNAME_LEN, P_QNAME_CHR, P_QTYPE, P_QCLASS, P_RNAME_LEN, P_RNAME_CHR,
    P_RTYPE, P_RCLASS, P_TTL, P_RDLEN, P_IPV4, P_PREF, P_DNAME_LEN, P_DNAME_CHR,
    P_FINISHED
  } parse_state_t;

  typedef enum logic [1:0] {F_IPV4, F_NAME, F_MX} data_fmt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // byte count codes: four bytes wrap the 2-bit counter to zero
  localparam logic [1:0] WORD16 = 2'd2;
  localparam logic [1:0] WORD32 = 2'd0;
  localparam int STALL_CYCLES = 300;

  logic clk;
  logic rst_n;

  drp_in_if  in_chan ();
  drp_out_if out_chan ();

  dns_response_parser uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  msg_byte_t  pending_bytes[$];
  msg_byte_t  next_byte;
  res_t       parsed_fields_due[$];
  logic [7:0] msg[$];
  int         len_marks[$];

  int bytes_queued = 0;
  int bytes_accepted = 0;
  int mismatches = 0;
  int src_idle_pct = 25;
  int sink_idle_pct = 59;
  bit stall_armed = 1'b0;
  int stall_count = 0;
  logic in_taken = 1'b0;

  // parser shadow state
  parse_state_t pstate;
  data_fmt_t    data_fmt;
  logic [1:0]   byte_cnt;
  logic [31:0]  accum;
  logic [5:0]   label_cnt;
  logic         in_name;
  logic [15:0]  q_type;
  logic [15:0]  an_left;
  logic [15:0]  ns_left;
  logic [15:0]  ar_left;
  logic [1:0]   cur_sect;
  logic         broken;
  int           results_this_byte;

  function automatic void clear_parse();
    pstate    = P_ID;
    data_fmt  = F_IPV4;
    byte_cnt  = '0;
    accum     = '0;
    label_cnt = '0;
    in_name   = 1'b0;
    q_type    = '0;
    an_left   = '0;
    ns_left   = '0;
    ar_left   = '0;
    cur_sect  = '0;
    broken    = 1'b0;
  endfunction

  function automatic void emit_field(logic [4:0] kind, logic [31:0] value);
    if (results_this_byte < 2) begin
      parsed_fields_due.push_back('{kind: kind, section: cur_sect, value: value});
      results_this_byte++;
    end
  endfunction

  function automatic void next_record();
    if (an_left != 0) begin
      an_left--;
      cur_sect = 2'd1;
    end else if (ns_left != 0) begin
      ns_left--;
      cur_sect = 2'd2;
    end else if (ar_left != 0) begin
      ar_left--;
      cur_sect = 2'd3;
    end else begin
      pstate = P_FINISHED;
      emit_field(K_DONE, 32'd0);
      return;
    end
    if (q_type == TYPE_A) data_fmt = F_IPV4;
    else if (q_type == TYPE_CNAME) data_fmt = F_NAME;
    else if (cur_sect == 2'd1) data_fmt = (q_type == TYPE_MX) ? F_MX : F_NAME;
    else if (cur_sect == 2'd2) data_fmt = F_NAME;
    else data_fmt = F_IPV4;
    pstate  = P_RNAME_LEN;
    in_name = 1'b0;
  endfunction

  function automatic bit shift_in(logic [7:0] b, logic [1:0] width_code);
    accum    = {accum[23:0], b};
    byte_cnt = byte_cnt + 2'd1;
    if (byte_cnt == width_code) begin
      byte_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 when the root label ends the name
  function automatic bit name_len(logic [7:0] b, parse_state_t chr_state);
    if (b == 8'd0) begin
      emit_field(K_NAME_END, 32'd0);
      return 1'b1;
    end
    if (b > LABEL_MAX) begin
      broken = 1'b1;
      emit_field(K_ERROR, ERR_BAD_LABEL);
      return 1'b0;
    end
    if (in_name) emit_field(K_NAME_CHAR, {24'd0, CHAR_DOT});
    in_name   = 1'b1;
    label_cnt = b[5:0];
    pstate    = chr_state;
    return 1'b0;
  endfunction

  function automatic void name_chr(logic [7:0] b, parse_state_t len_state);
    emit_field(K_NAME_CHAR, {24'd0, b});
    label_cnt = label_cnt - 6'd1;
    if (label_cnt == 6'd0) pstate = len_state;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    logic [15:0] w;
    results_this_byte = 0;
    if (broken || pstate == P_FINISHED) begin
      if (last) clear_parse();
      return;
    end
    case (pstate)
      P_ID, P_FLAGS, P_QDCOUNT, P_ANCOUNT, P_NSCOUNT, P_ARCOUNT: begin
        if (shift_in(b, WORD16)) begin
          w = accum[15:0];
          emit_field(K_ID + 5'(pstate), {16'd0, w});
          if (pstate == P_ANCOUNT) an_left = w;
          if (pstate == P_NSCOUNT) ns_left = w;
          if (pstate == P_ARCOUNT) ar_left = w;
          pstate = parse_state_t'(pstate + 5'd1);
          accum  = '0;
        end
      end
      P_QNAME_LEN: if (name_len(b, P_QNAME_CHR)) pstate = P_QTYPE;
      P_QNAME_CHR: name_chr(b, P_QNAME_LEN);
      P_QTYPE, P_QCLASS, P_RTYPE, P_RCLASS, P_RDLEN: begin
        if (shift_in(b, WORD16)) begin
          w     = accum[15:0];
          accum = '0;
          case (pstate)
            P_QTYPE: begin
              q_type = w;
              emit_field(K_QTYPE, {16'd0, w});
              pstate = P_QCLASS;
            end
            P_QCLASS: begin
              emit_field(K_QCLASS, {16'd0, w});
              next_record();
            end
            P_RTYPE: begin
              emit_field(K_RTYPE, {16'd0, w});
              pstate = P_RCLASS;
            end
            P_RCLASS: begin
              emit_field(K_RCLASS, {16'd0, w});
              pstate = P_TTL;
            end
            default: begin
              emit_field(K_RDLEN, {16'd0, w});
              in_name = 1'b0;
              if (data_fmt == F_IPV4) pstate = P_IPV4;
              else if (data_fmt == F_MX) pstate = P_PREF;
              else pstate = P_DNAME_LEN;
            end
          endcase
        end
      end
      P_RNAME_LEN: if (name_len(b, P_RNAME_CHR)) pstate = P_RTYPE;
      P_RNAME_CHR: name_chr(b, P_RNAME_LEN);
      P_TTL: begin
        if (shift_in(b, WORD32)) begin
          emit_field(K_TTL, accum);
          accum  = '0;
          pstate = P_RDLEN;
        end
      end
      P_IPV4: begin
        if (shift_in(b, WORD32)) begin
          emit_field(K_IPV4, accum);
          accum = '0;
          next_record();
        end
      end
      P_PREF: begin
        if (shift_in(b, WORD16)) begin
          accum  = '0;
          pstate = P_DNAME_LEN;
        end
      end
      P_DNAME_LEN: if (name_len(b, P_DNAME_CHR)) next_record();
      P_DNAME_CHR: name_chr(b, P_DNAME_LEN);
      default: begin
        broken = 1'b1;
        emit_field(K_ERROR, ERR_BAD_LABEL);
      end
    endcase
    if (last) begin
      if (!broken && pstate != P_FINISHED) emit_field(K_ERROR, ERR_TRUNCATED);
      clear_parse();
    end
  endfunction

  task automatic check_field(input res_t got);
    res_t want;
    if (parsed_fields_due.size() == 0) begin
      mismatches++;
      $error("unexpected result: field_kind %0d section %0d field_value %0h",
             got.kind, got.section, got.value);
    end else begin
      want = parsed_fields_due.pop_front();
      if (got.kind !== want.kind) begin
        mismatches++;
        $error("field_kind: expected %0d, got %0d", want.kind, got.kind);
      end
      if (got.section !== want.section) begin
        mismatches++;
        $error("section: expected %0d, got %0d", want.section, got.section);
      end
      if (got.value !== want.value) begin
        mismatches++;
        $error("field_value: expected %0h, got %0h", want.value, got.value);
      end
    end
  endtask

  // message building
  task automatic add_word(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) msg.push_back(v[8*i +: 8]);
  endtask

  task automatic add_name();
    int labels;
    int len;
    labels = $urandom_range(0, 3);
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(19) == 0) ? 63 : $urandom_range(1, 5);
      len_marks.push_back(msg.size());
      msg.push_back(8'(len));
      repeat (len) msg.push_back(8'($urandom_range(255)));
    end
    len_marks.push_back(msg.size());
    msg.push_back(8'h00);
  endtask

  task automatic add_record(input logic [15:0] qt, input int sect);
    data_fmt_t fmt;
    if (qt == TYPE_A) fmt = F_IPV4;
    else if (qt == TYPE_CNAME) fmt = F_NAME;
    else if (sect == 1) fmt = (qt == TYPE_MX) ? F_MX : F_NAME;
    else if (sect == 2) fmt = F_NAME;
    else fmt = F_IPV4;
    add_name();
    add_word(($urandom_range(3) == 0) ? {16'd0, TYPE_MX} : $urandom, 2);
    add_word($urandom, 2);
    add_word($urandom, 4);
    add_word($urandom, 2);
    case (fmt)
      F_IPV4: add_word($urandom, 4);
      F_MX: begin
        add_word($urandom, 2);
        add_name();
      end
      default: add_name();
    endcase
  endtask

  task automatic push_msg();
    foreach (msg[i]) begin
      pending_bytes.push_back('{data: msg[i], last: (i == msg.size() - 1)});
      bytes_queued++;
    end
  endtask

  task automatic add_message();
    int counts[3];
    int big_sect;
    int shape;
    int p;
    logic [15:0] qt;
    msg.delete();
    len_marks.delete();
    shape = $urandom_range(9);
    if (shape == 0) begin
      // noise
      repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom_range(255)));
      push_msg();
      return;
    end
    big_sect = ($urandom_range(11) == 0) ? $urandom_range(1, 3) : 0;
    for (int s = 0; s < 3; s++) counts[s] = $urandom_range(0, 2);
    add_word($urandom, 2);
    add_word($urandom, 2);
    add_word($urandom, 2);
    for (int s = 0; s < 3; s++)
      add_word((big_sect == s + 1) ? 32'hFFFF : 32'(counts[s]), 2);
    case ($urandom_range(3))
      0: qt = TYPE_A;
      1: qt = TYPE_CNAME;
      2: qt = TYPE_MX;
      default: qt = 16'($urandom);
    endcase
    add_name();
    add_word({16'd0, qt}, 2);
    add_word($urandom, 2);
    for (int s = 1; s <= 3; s++)
      for (int r = 0; r < counts[s-1]; r++) add_record(qt, s);
    if (big_sect == 0 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
    if (shape == 1) begin
      // early end
      p = $urandom_range(1, msg.size() - 1);
      while (msg.size() > p) void'(msg.pop_back());
    end else if (shape == 2) begin
      // bad label length
      p = len_marks[$urandom_range(0, len_marks.size() - 1)];
      msg[p] = 8'($urandom_range(64, 255));
    end
    push_msg();
  endtask

  task automatic add_random_messages(input int target);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < target) add_message();
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || parsed_fields_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // item sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        in_chan.valid     <= 1'b1;
        in_chan.data_byte <= next_byte.data;
        in_chan.frame_end <= next_byte.last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_armed && stall_count < STALL_CYCLES) begin
      out_chan.ready <= 1'b0;
      stall_count    <= stall_count + 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      parse_byte(in_chan.data_byte, in_chan.frame_end);
      bytes_accepted++;
    end
    if (rst_n && out_chan.valid && out_chan.ready)
      check_field('{kind: out_chan.field_kind, section: out_chan.section,
                    value: out_chan.field_value});
  end

  initial begin
    #2_000_000;
    $display("dns_response_parser test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.frame_end = 1'b0;
    out_chan.ready = 1'b0;
    clear_parse();

    // id word then early end on the same byte
    msg = '{8'hFF, 8'hFF};
    push_msg();
    // lone byte that ends the message
    msg = '{8'h00};
    push_msg();
    // smallest illegal label length, then ignored bytes up to the end
    msg = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h40, 8'h41, 8'h00};
    push_msg();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_random_messages(420);
    wait_drained();

    src_idle_pct  = 59;
    sink_idle_pct = 25;
    add_random_messages(420);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    add_random_messages(420);
    stall_armed = 1'b1;
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("dns_response_parser test passed");
    end else begin
      $display("dns_response_parser test failed");
    end
    $finish;
  end

endmodule
